// File: hw/rtl/mtrc_pkg.sv
// Shared types and constants for the Modbus TCP read-input-registers client.
// No dependencies; used by the serializer, the top level and the testbench.
`default_nettype none

package mtrc_pkg;

  // Input transaction kinds.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  // Result transaction kinds.
  typedef enum logic [1:0] {
    OUT_TX     = 2'd0,
    OUT_REG    = 2'd1,
    OUT_STATUS = 2'd2
  } out_kind_e;

  // Final status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EXCEPTION    = 3'd1,
    ST_BAD_COUNT    = 3'd2,
    ST_HDR_TIMEOUT  = 3'd3,
    ST_DATA_TIMEOUT = 3'd4
  } status_e;

  // Exchange phase.
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  // Configuration register indexes.
  localparam logic [7:0] CFG_UNIT_ID       = 8'd0;
  localparam logic [7:0] CFG_TIMEOUT_TICKS = 8'd1;

  localparam logic [7:0]  UNIT_ID_RESET  = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
  localparam logic [15:0] TID_RESET      = 16'd1;

  // Request frame constants.
  localparam logic [3:0] FRAME_LAST   = 4'd11;
  localparam logic [7:0] MBAP_LENGTH  = 8'd6;
  localparam logic [7:0] FUNC_READ_IR = 8'd4;

  // Header layout: function byte and byte count positions.
  localparam logic [3:0] HDR_FUNC_POS  = 4'd7;
  localparam logic [3:0] HDR_COUNT_POS = 4'd8;

  // Work handed from the parser to the output serializer.
  typedef struct packed {
    logic        frame;      // send the 12-byte request
    logic        reg_vld;    // send one register value
    logic        stat_vld;   // send a final status (after the register, if any)
    logic [15:0] tid;
    logic [7:0]  unit;
    logic [15:0] addr;
    logic [6:0]  cnt;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    status_e     status;
    logic [7:0]  exc_code;
  } desc_t;

endpackage

`default_nettype wire

// File: hw/rtl/mtrc_if.sv
// Valid/ready channel interfaces of the Modbus TCP client: input, result, config.
// Depends on nothing; payload widths follow the item fields.
`default_nettype none

interface mtrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] start_address;
  logic [6:0]  register_count;
  logic [7:0]  rx_byte;

  modport source (output valid, kind, start_address, register_count, rx_byte,
                  input ready);
  modport sink   (input valid, kind, start_address, register_count, rx_byte,
                  output ready);
endinterface

interface mtrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [15:0] reg_value;
  logic [6:0]  reg_index;
  logic [2:0]  status;
  logic [7:0]  exception_code;

  modport source (output valid, out_kind, tx_byte, tx_last, reg_value, reg_index,
                  status, exception_code, input ready);
  modport sink   (input valid, out_kind, tx_byte, tx_last, reg_value, reg_index,
                  status, exception_code, output ready);
endinterface

interface mtrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/modbus_tcp_read_input_client.sv
// Top level of the Modbus TCP client for Read Input Registers (function 4).
// Depends on mtrc_pkg, mtrc_if and mtrc_serializer.
//
//   channel  dir  transaction carries
//   in_i     in   kind, start_address, register_count, rx_byte
//   out_o    out  out_kind, tx_byte, tx_last, reg_value, reg_index, status,
//                 exception_code
//   cfg_i    in   addr (0 unit_id, 1 timeout_ticks), data
//
// A received byte or a tick is taken when the output register can load; the parser
// updates its counters at acceptance and loads the results into the output register.
// A start transaction yields 12 request bytes, so the output register holds the
// input back until the last one is taken; a register followed by OK is two results.
// A new input transaction is taken in the same cycle as the last pending result.
// Reset clears the phase and counters, sets unit_id 1, timeout 500, id 1.
// Configuration writes are always taken and apply at once.
`default_nettype none

module modbus_tcp_read_input_client #(
  parameter int unsigned MAX_REGISTERS = 125
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  mtrc_in_if.sink     in_i,
  mtrc_out_if.source  out_o,
  mtrc_cfg_if.sink    cfg_i
);

  // Configuration registers.
  logic [7:0]  unit_q;
  logic [15:0] timeout_q;

  // Exchange state.
  mtrc_pkg::phase_e phase_q, phase_d;
  logic [15:0] tid_q, tid_d;
  logic [3:0]  hpos_q, hpos_d;
  logic        exc_q, exc_d;
  logic [6:0]  exp_q, exp_d;
  logic [7:0]  dpos_q, dpos_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic            accept, can_load, load;
  mtrc_pkg::desc_t desc;
  logic [6:0]      cnt_sat;
  logic [15:0]     el_inc;
  logic [7:0]      exp_bytes;
  logic [8:0]      dpos_inc;

  assign in_i.ready  = can_load;
  assign accept      = in_i.valid & in_i.ready;
  assign load        = accept & (desc.frame | desc.reg_vld | desc.stat_vld);
  assign cfg_i.ready = 1'b1;

  // Clamp the requested count to the supported maximum.
  assign cnt_sat   = (in_i.register_count > 7'(MAX_REGISTERS)) ? 7'(MAX_REGISTERS)
                                                                : in_i.register_count;
  assign el_inc    = elapsed_q + 16'd1;
  assign exp_bytes = {exp_q, 1'b0};
  assign dpos_inc  = {1'b0, dpos_q} + 9'd1;

  always_comb begin
    phase_d   = phase_q;
    tid_d     = tid_q;
    hpos_d    = hpos_q;
    exc_d     = exc_q;
    exp_d     = exp_q;
    dpos_d    = dpos_q;
    held_d    = held_q;
    elapsed_d = elapsed_q;
    desc      = '0;
    desc.status = mtrc_pkg::ST_OK;
    if (accept) begin
      case (mtrc_pkg::kind_e'(in_i.kind))
        mtrc_pkg::KIND_START: begin
          // Drop any exchange in flight and send a fresh request.
          desc.frame = 1'b1;
          desc.tid   = tid_q;
          desc.unit  = unit_q;
          desc.addr  = in_i.start_address - 16'd1;
          desc.cnt   = cnt_sat;
          tid_d      = tid_q + 16'd1;
          phase_d    = mtrc_pkg::PH_HEADER;
          hpos_d     = 4'd0;
          exc_d      = 1'b0;
          exp_d      = cnt_sat;
          dpos_d     = 8'd0;
          held_d     = 8'd0;
          elapsed_d  = 16'd0;
        end
        mtrc_pkg::KIND_TICK: begin
          if (phase_q != mtrc_pkg::PH_IDLE) begin
            elapsed_d = el_inc;
            if (el_inc >= timeout_q || el_inc == 16'd0) begin
              desc.stat_vld = 1'b1;
              desc.status   = (phase_q == mtrc_pkg::PH_HEADER) ? mtrc_pkg::ST_HDR_TIMEOUT
                                                               : mtrc_pkg::ST_DATA_TIMEOUT;
              phase_d       = mtrc_pkg::PH_IDLE;
            end
          end
        end
        mtrc_pkg::KIND_BYTE: begin
          case (phase_q)
            mtrc_pkg::PH_HEADER: begin
              // Only the function byte's exception bit and the byte count matter.
              if (hpos_q == mtrc_pkg::HDR_FUNC_POS) begin
                exc_d = in_i.rx_byte[7];
              end
              if (hpos_q < mtrc_pkg::HDR_COUNT_POS) begin
                hpos_d = hpos_q + 4'd1;
              end else begin
                hpos_d = 4'd0;
                if (exc_q) begin
                  desc.stat_vld = 1'b1;
                  desc.status   = mtrc_pkg::ST_EXCEPTION;
                  desc.exc_code = in_i.rx_byte;
                  phase_d       = mtrc_pkg::PH_IDLE;
                end else if (in_i.rx_byte != exp_bytes) begin
                  desc.stat_vld = 1'b1;
                  desc.status   = mtrc_pkg::ST_BAD_COUNT;
                  phase_d       = mtrc_pkg::PH_IDLE;
                end else if (exp_q == 7'd0) begin
                  desc.stat_vld = 1'b1;
                  phase_d       = mtrc_pkg::PH_IDLE;
                end else begin
                  phase_d   = mtrc_pkg::PH_DATA;
                  dpos_d    = 8'd0;
                  elapsed_d = 16'd0;
                end
              end
            end
            mtrc_pkg::PH_DATA: begin
              dpos_d = dpos_inc[7:0];
              if (!dpos_q[0]) begin
                // hold the high byte until its partner arrives
                held_d = in_i.rx_byte;
              end else begin
                desc.reg_vld   = 1'b1;
                desc.reg_value = {held_q, in_i.rx_byte};
                desc.reg_index = dpos_q[7:1];
                if (dpos_inc >= {1'b0, exp_bytes}) begin
                  desc.stat_vld = 1'b1;
                  phase_d       = mtrc_pkg::PH_IDLE;
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mtrc_pkg::PH_IDLE;
      tid_q     <= mtrc_pkg::TID_RESET;
      hpos_q    <= 4'd0;
      exc_q     <= 1'b0;
      exp_q     <= 7'd0;
      dpos_q    <= 8'd0;
      held_q    <= 8'd0;
      elapsed_q <= 16'd0;
    end else begin
      phase_q   <= phase_d;
      tid_q     <= tid_d;
      hpos_q    <= hpos_d;
      exc_q     <= exc_d;
      exp_q     <= exp_d;
      dpos_q    <= dpos_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q    <= mtrc_pkg::UNIT_ID_RESET;
      timeout_q <= mtrc_pkg::TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.addr == mtrc_pkg::CFG_UNIT_ID) begin
        unit_q <= cfg_i.data[7:0];
      end else if (cfg_i.addr == mtrc_pkg::CFG_TIMEOUT_TICKS) begin
        timeout_q <= cfg_i.data;
      end
    end
  end

  mtrc_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .desc_i     (desc),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/mtrc_serializer.sv
// Output stage: holds one work descriptor and emits its result transactions in order.
// Depends on mtrc_pkg and mtrc_if.
`default_nettype none

module mtrc_serializer (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  mtrc_pkg::desc_t     desc_i,
  output logic                can_load_o,
  mtrc_out_if.source          out_o
);

  logic            frame_q, frame_d;
  logic            reg_q, reg_d;
  logic            stat_q, stat_d;
  logic [3:0]      pos_q, pos_d;
  mtrc_pkg::desc_t desc_q;

  logic have, take, last;
  logic [7:0] tx_byte;

  assign have = frame_q | reg_q | stat_q;
  assign take = out_o.valid & out_o.ready;
  assign last = take & (frame_q ? (pos_q == mtrc_pkg::FRAME_LAST) : (reg_q ? !stat_q : 1'b1));
  assign can_load_o = !have | last;

  always_comb begin
    case (pos_q)
      4'd0:    tx_byte = desc_q.tid[15:8];
      4'd1:    tx_byte = desc_q.tid[7:0];
      4'd5:    tx_byte = mtrc_pkg::MBAP_LENGTH;
      4'd6:    tx_byte = desc_q.unit;
      4'd7:    tx_byte = mtrc_pkg::FUNC_READ_IR;
      4'd8:    tx_byte = desc_q.addr[15:8];
      4'd9:    tx_byte = desc_q.addr[7:0];
      4'd11:   tx_byte = {1'b0, desc_q.cnt};
      default: tx_byte = 8'd0;
    endcase
  end

  always_comb begin
    out_o.valid          = have;
    out_o.out_kind       = mtrc_pkg::OUT_STATUS;
    out_o.tx_byte        = 8'd0;
    out_o.tx_last        = 1'b0;
    out_o.reg_value      = 16'd0;
    out_o.reg_index      = 7'd0;
    out_o.status         = mtrc_pkg::ST_OK;
    out_o.exception_code = 8'd0;
    if (frame_q) begin
      out_o.out_kind = mtrc_pkg::OUT_TX;
      out_o.tx_byte  = tx_byte;
      out_o.tx_last  = (pos_q == mtrc_pkg::FRAME_LAST);
    end else if (reg_q) begin
      out_o.out_kind  = mtrc_pkg::OUT_REG;
      out_o.reg_value = desc_q.reg_value;
      out_o.reg_index = desc_q.reg_index;
    end else begin
      out_o.status         = desc_q.status;
      out_o.exception_code = desc_q.exc_code;
    end
  end

  always_comb begin
    frame_d = frame_q;
    reg_d   = reg_q;
    stat_d  = stat_q;
    pos_d   = pos_q;
    if (load_i) begin
      frame_d = desc_i.frame;
      reg_d   = desc_i.reg_vld;
      stat_d  = desc_i.stat_vld;
      pos_d   = 4'd0;
    end else if (take) begin
      if (frame_q) begin
        // advance through the frame, drop it after the last byte
        if (pos_q == mtrc_pkg::FRAME_LAST) begin
          frame_d = 1'b0;
        end else begin
          pos_d = pos_q + 4'd1;
        end
      end else if (reg_q) begin
        reg_d = 1'b0;
      end else begin
        stat_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= 1'b0;
      reg_q   <= 1'b0;
      stat_q  <= 1'b0;
      pos_q   <= 4'd0;
    end else begin
      frame_q <= frame_d;
      reg_q   <= reg_d;
      stat_q  <= stat_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

endmodule

`default_nettype wire

// File: verif/read_ir_check_pkg.sv
// Checking side of the Modbus TCP read-input-registers client testbench.
// Holds the item and result types and the predicting scoreboard; needs mtrc_pkg.
package read_ir_check_pkg;

  import mtrc_pkg::*;

  localparam int         MAX_REGS   = 125;
  localparam logic [1:0] KIND_SPARE = 2'd3;   // unused input kind, must be ignored
  localparam logic [7:0] EXC_MASK   = 8'h80;  // exception bit of the function byte

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start_address;
    logic [6:0]  register_count;
    logic [7:0]  rx_byte;
  } ir_item_t;

  typedef struct packed {
    out_kind_e   kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    status_e     status;
    logic [7:0]  exc_code;
  } ir_result_t;

  class read_ir_tracker;
    logic [7:0]  unit_id;
    logic [15:0] tmo_ticks;
    phase_e      ph;
    logic [15:0] tid;
    logic [3:0]  hdr_pos;
    logic        exc_seen;
    logic [6:0]  want_regs;
    logic [7:0]  data_pos;
    logic [7:0]  high_byte;
    logic [15:0] ticks;

    ir_result_t  awaited[$];
    int          failures;
    int          reported;

    function new();
      unit_id   = UNIT_ID_RESET;
      tmo_ticks = TIMEOUT_RESET;
      ph        = PH_IDLE;
      tid       = TID_RESET;
      hdr_pos   = '0;
      exc_seen  = 1'b0;
      want_regs = '0;
      data_pos  = '0;
      high_byte = '0;
      ticks     = '0;
      failures  = 0;
      reported  = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == CFG_UNIT_ID) begin
        unit_id = data[7:0];
      end else if (idx == CFG_TIMEOUT_TICKS) begin
        tmo_ticks = data;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void emit(out_kind_e k, logic [7:0] tx, logic last, logic [15:0] val,
                       logic [6:0] idx, status_e st, logic [7:0] code);
      ir_result_t r;
      r.kind      = k;
      r.tx_byte   = tx;
      r.tx_last   = last;
      r.reg_value = val;
      r.reg_index = idx;
      r.status    = st;
      r.exc_code  = code;
      awaited.push_back(r);
    endfunction

    function void close_exchange(status_e st, logic [7:0] code);
      emit(OUT_STATUS, 8'h00, 1'b0, 16'h0000, 7'd0, st, code);
      ph = PH_IDLE;
    endfunction

    // Advance the client by one accepted input; return 0 when it is ignored.
    function bit note_item(ir_item_t it);
      logic [15:0] addr;
      logic [6:0]  cnt;
      logic [7:0]  frame[12];
      logic [7:0]  b;
      b = it.rx_byte;
      if (it.kind == KIND_START) begin
        addr = it.start_address - 16'd1;
        cnt  = (it.register_count > MAX_REGS) ? 7'(MAX_REGS) : it.register_count;
        frame[0]  = tid[15:8];
        frame[1]  = tid[7:0];
        frame[2]  = 8'h00;
        frame[3]  = 8'h00;
        frame[4]  = 8'h00;
        frame[5]  = MBAP_LENGTH;
        frame[6]  = unit_id;
        frame[7]  = FUNC_READ_IR;
        frame[8]  = addr[15:8];
        frame[9]  = addr[7:0];
        frame[10] = 8'h00;
        frame[11] = {1'b0, cnt};
        tid = tid + 16'd1;
        for (int i = 0; i < 12; i++) begin
          emit(OUT_TX, frame[i], i == FRAME_LAST, 16'h0000, 7'd0, ST_OK, 8'h00);
        end
        // a start always drops whatever exchange was in flight
        ph        = PH_HEADER;
        hdr_pos   = '0;
        exc_seen  = 1'b0;
        want_regs = cnt;
        data_pos  = '0;
        high_byte = '0;
        ticks     = '0;
        return 1'b1;
      end
      if (ph == PH_IDLE || !(it.kind == KIND_TICK || it.kind == KIND_BYTE)) return 1'b0;
      if (it.kind == KIND_TICK) begin
        ticks = ticks + 16'd1;
        if (ticks >= tmo_ticks || ticks == 16'd0) begin
          close_exchange(ph == PH_HEADER ? ST_HDR_TIMEOUT : ST_DATA_TIMEOUT, 8'h00);
        end
        return 1'b1;
      end
      if (ph == PH_HEADER) begin
        if (hdr_pos == HDR_FUNC_POS) exc_seen = (b & EXC_MASK) != 8'h00;
        if (hdr_pos < HDR_COUNT_POS) begin
          hdr_pos = hdr_pos + 4'd1;
        end else begin
          hdr_pos = '0;
          if (exc_seen) begin
            close_exchange(ST_EXCEPTION, b);
          end else if (b != {want_regs, 1'b0}) begin
            close_exchange(ST_BAD_COUNT, 8'h00);
          end else if (want_regs == 7'd0) begin
            close_exchange(ST_OK, 8'h00);
          end else begin
            ph       = PH_DATA;
            data_pos = '0;
            ticks    = '0;
          end
        end
        return 1'b1;
      end
      // data phase: even positions hold the high byte, odd ones complete a register
      if (!data_pos[0]) begin
        high_byte = b;
      end else begin
        emit(OUT_REG, 8'h00, 1'b0, {high_byte, b}, data_pos[7:1], ST_OK, 8'h00);
      end
      data_pos = data_pos + 8'd1;
      if (!data_pos[0] && data_pos >= {want_regs, 1'b0}) close_exchange(ST_OK, 8'h00);
      return 1'b1;
    endfunction

    function string show(ir_result_t r);
      return $sformatf("kind=%0d tx=%02h last=%0d reg=%04h idx=%0d st=%0d exc=%02h",
                       r.kind, r.tx_byte, r.tx_last, r.reg_value, r.reg_index,
                       r.status, r.exc_code);
    endfunction

    function void check_result(ir_result_t got);
      ir_result_t exp;
      if (awaited.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("%0t: result with nothing awaited: %s", $time, show(got));
        end
        return;
      end
      exp = awaited.pop_front();
      if (got.kind !== exp.kind || got.tx_byte !== exp.tx_byte ||
          got.tx_last !== exp.tx_last || got.reg_value !== exp.reg_value ||
          got.reg_index !== exp.reg_index || got.status !== exp.status ||
          got.exc_code !== exp.exc_code) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("%0t: mismatch\n  expected %s\n  actual   %s", $time, show(exp),
                   show(got));
        end
      end
    endfunction
  endclass

endpackage

// File: verif/testbench.sv
// Top-level testbench of modbus_tcp_read_input_client: random and directed traffic.
// Needs mtrc_pkg, the mtrc channel interfaces and read_ir_check_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtrc_pkg::*;
  import read_ir_check_pkg::*;

  logic clk_i;
  logic rst_n;

  mtrc_in_if  in_if();
  mtrc_out_if out_if();
  mtrc_cfg_if cfg_if();

  modbus_tcp_read_input_client #(
    .MAX_REGISTERS(MAX_REGS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  read_ir_tracker trk = new();

  bit          tx_fast;      // sender offers back to back
  bit          rx_fast;      // receiver never stalls
  int          hold_cycles;  // one-shot long stall request for the receiver
  int          live_items;   // transactions that moved the client's state
  logic [15:0] cur_tmo = TIMEOUT_RESET;

  // Run the 12 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // End the run if it hangs.
  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: stall a random number of cycles before every result transaction,
  // or hold off for a long stretch when the stimulus asks for it, so that the
  // output register fills and the block stops taking input.
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = rx_fast ? 0 : $urandom_range(0, 14);
      end
      repeat (n) begin
        @(negedge clk_i);
        out_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Sample every accepted result at the rising edge and check it in order.
  always @(posedge clk_i) begin
    ir_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind      = out_kind_e'(out_if.out_kind);
      got.tx_byte   = out_if.tx_byte;
      got.tx_last   = out_if.tx_last;
      got.reg_value = out_if.reg_value;
      got.reg_index = out_if.reg_index;
      got.status    = status_e'(out_if.status);
      got.exc_code  = out_if.exception_code;
      trk.check_result(got);
    end
  end

  // Offer one input transaction after a random gap; note it once accepted.
  task automatic send(logic [1:0] k, logic [15:0] a, logic [6:0] c, logic [7:0] b);
    ir_item_t it;
    int       gap;
    it.kind           = k;
    it.start_address  = a;
    it.register_count = c;
    it.rx_byte        = b;
    gap = tx_fast ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid          <= 1'b1;
    in_if.kind           <= k;
    in_if.start_address  <= a;
    in_if.register_count <= c;
    in_if.rx_byte        <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (trk.note_item(it)) live_items++;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Unused fields carry random values; the block must not look at them.
  task automatic send_start(logic [15:0] a, logic [6:0] c);
    send(KIND_START, a, c, rand_byte());
  endtask

  task automatic send_byte(logic [7:0] b);
    send(KIND_BYTE, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)), b);
  endtask

  task automatic send_tick();
    send(KIND_TICK, 16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
         rand_byte());
  endtask

  task automatic maybe_tick();
    if ($urandom_range(0, 15) == 0) send_tick();
  endtask

  // Send a 9-byte response header: seven unchecked bytes, function, byte count.
  task automatic send_header(logic [7:0] func, logic [7:0] count, bit with_ticks);
    for (int i = 0; i < 7; i++) begin
      if (with_ticks) maybe_tick();
      send_byte(rand_byte());
    end
    if (with_ticks) maybe_tick();
    send_byte(func);
    if (with_ticks) maybe_tick();
    send_byte(count);
  endtask

  // Ticks enough to run out the current timeout when it is short.
  function automatic int tick_budget();
    if (cur_tmo == 16'd0) return 1;
    return (cur_tmo <= 16'd20) ? int'(cur_tmo) : 3;
  endfunction

  // Drop valid and wait until the block has drained every awaited result.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [15:0] val);
    settle();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    trk.write_reg(idx, val);
    if (idx == CFG_TIMEOUT_TICKS) cur_tmo = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One exchange: mostly well-formed request/response with random content,
  // the rest exceptions, bad byte counts, timeouts, restarts and noise.
  task automatic run_exchange();
    int          mode;
    int          c;
    int          eff;
    int          n;
    logic [7:0]  fb;
    logic [7:0]  cb;
    mode    = $urandom_range(0, 15);
    tx_fast = ($urandom_range(0, 4) == 0);
    rx_fast = ($urandom_range(0, 4) == 0);
    if (mode == 15) begin
      repeat ($urandom_range(1, 4)) begin
        send(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
             7'($urandom_range(0, 127)), rand_byte());
      end
      return;
    end
    case ($urandom_range(0, 29))
      0:       c = 0;
      1:       c = $urandom_range(64, 127);
      default: c = $urandom_range(1, 6);
    endcase
    eff = (c > MAX_REGS) ? MAX_REGS : c;
    send_start(16'($urandom_range(0, 65535)), 7'(c));
    // restart mid-header, or let the header time out
    if (mode == 8 || mode == 10) begin
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) send_byte(rand_byte());
      if (mode == 8) repeat (tick_budget()) send_tick();
      return;
    end
    fb = FUNC_READ_IR;
    if (mode == 6) fb = rand_byte() | EXC_MASK;
    else if (mode == 5) fb = rand_byte() & ~EXC_MASK;
    cb = 8'(2 * eff);
    if (mode == 6) cb = rand_byte();
    else if (mode == 7) cb = cb ^ 8'($urandom_range(1, 255));
    send_header(fb, cb, 1'b1);
    if (mode == 6 || mode == 7) return;
    n = 2 * eff;
    if (mode == 9 && eff > 0) n = $urandom_range(0, 2 * eff - 1);
    for (int i = 0; i < n; i++) begin
      maybe_tick();
      send_byte(rand_byte());
    end
    if (mode == 9) repeat (tick_budget()) send_tick();
  endtask

  initial begin
    logic [7:0]  u;
    logic [15:0] t;
    int          goal;
    in_if.valid          = 1'b0;
    in_if.kind           = KIND_START;
    in_if.start_address  = '0;
    in_if.register_count = '0;
    in_if.rx_byte        = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.addr          = CFG_UNIT_ID;
    cfg_if.data          = '0;
    rst_n                = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Directed: reset settings, address zero wrapping to 0xFFFF, one register.
    send_start(16'h0000, 7'd1);
    send_header(FUNC_READ_IR, 8'd2, 1'b0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // Idle: the spare kind, a stray byte and a stray tick all do nothing.
    send(KIND_SPARE, 16'hFFFF, 7'd127, 8'hFF);
    send_byte(8'h00);
    send_tick();
    // Top unit id, shortest timeout, top address and a count to saturate.
    write_cfg(CFG_UNIT_ID, 16'h00FF);
    write_cfg(CFG_TIMEOUT_TICKS, 16'd1);
    send_start(16'hFFFF, 7'd127);
    send_tick();
    // Zero timeout: a zero-count request completes; the first tick expires.
    write_cfg(CFG_TIMEOUT_TICKS, 16'd0);
    send_start(16'd1, 7'd0);
    send_header(FUNC_READ_IR, 8'd0, 1'b0);
    send_start(16'h8000, 7'd126);
    send_tick();

    // Random phases, each under its own unit id and timeout.
    for (int p = 0; p < 5; p++) begin
      u = 8'($urandom_range(0, 255));
      case (p)
        0:       t = 16'd6;
        1:       begin u = 8'h00; t = 16'hFFFF; end
        2:       begin u = 8'hFF; t = 16'd1; end
        3:       t = 16'($urandom_range(2, 20));
        default: t = TIMEOUT_RESET;
      endcase
      write_cfg(CFG_UNIT_ID, {8'h00, u});
      write_cfg(CFG_TIMEOUT_TICKS, t);
      // Stall the receiver long enough to back up the input side.
      if (p == 1) hold_cycles = 400;
      goal = live_items + 100;
      while (live_items < goal) run_exchange();
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (trk.failures == 0 && trk.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/mtrc_pkg.sv
hw/rtl/mtrc_if.sv
hw/rtl/mtrc_serializer.sv
hw/rtl/modbus_tcp_read_input_client.sv
verif/read_ir_check_pkg.sv
verif/testbench.sv
